>>> src/minicomputer_alu_condition_codes_defines.svh
// Assertion macros shared by the condition-code ALU files.
`ifndef MINICOMPUTER_ALU_CONDITION_CODES_DEFINES_SVH
`define MINICOMPUTER_ALU_CONDITION_CODES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCALU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCALU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mcalu_pkg.sv
// Types, codes and helper functions of the condition-code ALU.
package mcalu_pkg;

    // Operation codes carried in the func field.
    typedef enum logic [4:0] {
        FN_CLR  = 5'd0,
        FN_TST  = 5'd1,
        FN_COM  = 5'd2,
        FN_INC  = 5'd3,
        FN_DEC  = 5'd4,
        FN_NEG  = 5'd5,
        FN_ADC  = 5'd6,
        FN_SBC  = 5'd7,
        FN_ROR  = 5'd8,
        FN_ROL  = 5'd9,
        FN_ASR  = 5'd10,
        FN_ASL  = 5'd11,
        FN_MOV  = 5'd12,
        FN_CMP  = 5'd13,
        FN_BIT  = 5'd14,
        FN_BIC  = 5'd15,
        FN_BIS  = 5'd16,
        FN_ADD  = 5'd17,
        FN_SUB  = 5'd18,
        FN_SWAB = 5'd19,
        FN_SXT  = 5'd20,
        FN_CLF  = 5'd21,
        FN_SEF  = 5'd22,
        FN_BRT  = 5'd23,
        FN_XOR  = 5'd24
    } alu_func_t;

    // Branch condition codes.
    typedef enum logic [3:0] {
        BC_BR   = 4'd0,
        BC_BNE  = 4'd1,
        BC_BEQ  = 4'd2,
        BC_BGE  = 4'd3,
        BC_BLT  = 4'd4,
        BC_BGT  = 4'd5,
        BC_BLE  = 4'd6,
        BC_BPL  = 4'd7,
        BC_BMI  = 4'd8,
        BC_BHI  = 4'd9,
        BC_BLOS = 4'd10,
        BC_BVC  = 4'd11,
        BC_BVS  = 4'd12,
        BC_BCC  = 4'd13,
        BC_BCS  = 4'd14
    } branch_code_t;

    // Condition code bit positions within the four-bit flag word.
    localparam int FLG_N = 3;
    localparam int FLG_Z = 2;
    localparam int FLG_V = 1;
    localparam int FLG_C = 0;

    // Word and byte masks and sign bits.
    localparam logic [15:0] MASK_WORD = 16'hFFFF;
    localparam logic [15:0] MASK_BYTE = 16'h00FF;
    localparam logic [15:0] SIGN_WORD = 16'h8000;
    localparam logic [15:0] SIGN_BYTE = 16'h0080;

    // One input item.
    typedef struct packed {
        logic [3:0]  branch_code;
        logic [3:0]  flag_mask;
        logic [15:0] dst_value;
        logic [15:0] src_value;
        logic        byte_mode;
        logic [4:0]  func;
    } alu_in_t;

    // One result item.
    typedef struct packed {
        logic        illegal;
        logic        branch_taken;
        logic [3:0]  new_flags;
        logic        write_back;
        logic [15:0] result;
    } alu_out_t;

    // Outcome of a branch condition test.
    typedef struct packed {
        logic taken;
        logic bad;
    } br_status_t;

    // Sign bit of a value in the selected operand size.
    function automatic logic msb_of(input logic [15:0] val, input logic byte_sel);
        msb_of = byte_sel ? val[7] : val[15];
    endfunction

    // N and Z flags of an already masked result.
    function automatic logic [3:0] nz_of(input logic [15:0] val, input logic byte_sel);
        logic [3:0] f;
        f = 4'b0000;
        f[FLG_N] = msb_of(val, byte_sel);
        f[FLG_Z] = (val == 16'h0000);
        nz_of = f;
    endfunction

endpackage

>>> src/minicomputer_alu_condition_codes.sv
// Top level of the condition-code ALU: input register, execution logic, result register.
//
// An accepted item is held in the input register until the result register can load.
// Its result is then loaded into the result register and shown on the output, and it is
// taken there once the output is ready. A new item is accepted every cycle while
// results are taken. One input register feeds the single-pass execution logic, whose
// outcome and the updated N, Z, V, C codes are loaded together into the result register.
// The codes are held in one register and read by the next item as it passes through
// execution. An item in the input register waits there while a result stalls, so one
// further item can be taken before the input side stalls too. Reset clears the codes.
`include "minicomputer_alu_condition_codes_defines.svh"

module minicomputer_alu_condition_codes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_value[15:0], dst_value[31:16], flag_mask[35:32], branch_code[39:36]
    input  logic [39:0] s_axis_tdata,
    // func[4:0], byte_mode[5]
    input  logic [5:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[15:0], write_back[16], new_flags[20:17], branch_taken[21],
    // illegal[22], zero fill[23]
    output logic [23:0] m_axis_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    mcalu_pkg::alu_in_t    in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    mcalu_pkg::alu_out_t   out_item_reg;
    logic [3:0]            flags_reg;
    mcalu_pkg::alu_out_t   exec_res;
    logic                  advance;
    logic                  in_accept;
    logic                  load_out;
    logic                  flags_agree;
    logic                  illegal_shown;
    logic                  out_quiet;

    // The result register can load when it is empty or being emptied.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign load_out      = advance && in_valid_reg;

    // Valid bits of the two stages.
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 4'b0000;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                flags_reg <= exec_res.new_flags;
            end
        end
    end

    // Input item register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.func        <= s_axis_tuser[4:0];
            in_item_reg.byte_mode   <= s_axis_tuser[5];
            in_item_reg.src_value   <= s_axis_tdata[15:0];
            in_item_reg.dst_value   <= s_axis_tdata[31:16];
            in_item_reg.flag_mask   <= s_axis_tdata[35:32];
            in_item_reg.branch_code <= s_axis_tdata[39:36];
        end
    end

    mcalu_exec u_exec (
        .item  (in_item_reg),
        .flags (flags_reg),
        .res   (exec_res)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_item_reg <= exec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_item_reg};

    // Terms checked by the assertions below.
    assign flags_agree   = (out_item_reg.new_flags == flags_reg);
    assign illegal_shown = m_axis_tvalid && out_item_reg.illegal;
    assign out_quiet     = !out_item_reg.write_back && !out_item_reg.branch_taken &&
                           (out_item_reg.result == 16'h0000);

    // A finished item always reaches the output stage.
    `MCALU_ASSERT_NXT(a_item_moves, clk, rst_n, load_out, m_axis_tvalid, "item lost")

    // Condition codes change only when an item passes through execution.
    `MCALU_ASSERT_NXT(a_flags_hold, clk, rst_n, !load_out, $stable(flags_reg), "codes changed")

    // The shown result carries the codes currently held.
    `MCALU_ASSERT_IMP(a_flags_match, clk, rst_n, m_axis_tvalid, flags_agree, "codes differ")

    // An illegal item stores nothing and takes no branch.
    `MCALU_ASSERT_IMP(a_illegal_quiet, clk, rst_n, illegal_shown, out_quiet, "illegal acts")

endmodule

>>> src/mcalu_branch.sv
// Branch condition evaluation against the current condition codes.
module mcalu_branch (
    input  logic [3:0]              branch_code,
    input  logic [3:0]              flags,
    output mcalu_pkg::br_status_t   status
);

    logic n;
    logic z;
    logic v;
    logic c;

    assign n = flags[mcalu_pkg::FLG_N];
    assign z = flags[mcalu_pkg::FLG_Z];
    assign v = flags[mcalu_pkg::FLG_V];
    assign c = flags[mcalu_pkg::FLG_C];

    // Decode the condition; the one unused code is reported as bad.
    always_comb
    begin
        status.taken = 1'b0;
        status.bad   = 1'b0;
        case (mcalu_pkg::branch_code_t'(branch_code))
            mcalu_pkg::BC_BR:   status.taken = 1'b1;
            mcalu_pkg::BC_BNE:  status.taken = !z;
            mcalu_pkg::BC_BEQ:  status.taken = z;
            mcalu_pkg::BC_BGE:  status.taken = (n == v);
            mcalu_pkg::BC_BLT:  status.taken = (n != v);
            mcalu_pkg::BC_BGT:  status.taken = !z && (n == v);
            mcalu_pkg::BC_BLE:  status.taken = z || (n != v);
            mcalu_pkg::BC_BPL:  status.taken = !n;
            mcalu_pkg::BC_BMI:  status.taken = n;
            mcalu_pkg::BC_BHI:  status.taken = !c && !z;
            mcalu_pkg::BC_BLOS: status.taken = c || z;
            mcalu_pkg::BC_BVC:  status.taken = !v;
            mcalu_pkg::BC_BVS:  status.taken = v;
            mcalu_pkg::BC_BCC:  status.taken = !c;
            mcalu_pkg::BC_BCS:  status.taken = c;
            default:            status.bad   = 1'b1;
        endcase
    end

endmodule

>>> src/mcalu_exec.sv
// Single-pass execution of one ALU operation and its condition codes.
module mcalu_exec (
    input  mcalu_pkg::alu_in_t   item,
    input  logic [3:0]           flags,
    output mcalu_pkg::alu_out_t  res
);

    logic                    byte_sel;
    logic [15:0]             m;
    logic [15:0]             sb;
    logic [15:0]             sm;
    logic [15:0]             dm;
    logic                    cin;
    logic [15:0]             cin16;
    logic [15:0]             sb_cin;
    logic [15:0]             diff_a;
    logic [15:0]             diff_b;
    logic [15:0]             diff;
    logic [16:0]             add_full;
    logic [15:0]             add_r;
    logic [15:0]             shl;
    logic                    sh_c;
    logic [15:0]             sh_r;
    logic [3:0]              sh_nz;
    mcalu_pkg::br_status_t   br;

    // Operand size selection: byte mode applies to the first seventeen operations.
    assign byte_sel = item.byte_mode && (item.func <= mcalu_pkg::FN_BIS);
    assign m        = byte_sel ? mcalu_pkg::MASK_BYTE : mcalu_pkg::MASK_WORD;
    assign sb       = byte_sel ? mcalu_pkg::SIGN_BYTE : mcalu_pkg::SIGN_WORD;
    assign sm       = item.src_value & m;
    assign dm       = item.dst_value & m;
    assign cin      = flags[mcalu_pkg::FLG_C];
    assign cin16    = {15'd0, cin};
    assign sb_cin   = cin ? sb : 16'h0000;

    // Shared subtractor for CMP (source minus destination) and SUB.
    assign diff_a = (item.func == mcalu_pkg::FN_CMP) ? sm : dm;
    assign diff_b = (item.func == mcalu_pkg::FN_CMP) ? dm : sm;
    assign diff   = (diff_a - diff_b) & m;

    // Word adder with carry out for ADD.
    assign add_full = {1'b0, dm} + {1'b0, sm};
    assign add_r    = add_full[15:0];

    // Shifts and rotates share one result selection and flag rule.
    assign shl = dm << 1;
    always_comb
    begin
        sh_c = 1'b0;
        sh_r = 16'h0000;
        case (mcalu_pkg::alu_func_t'(item.func))
            mcalu_pkg::FN_ROR:
            begin
                sh_c = dm[0];
                sh_r = (dm >> 1) | sb_cin;
            end
            mcalu_pkg::FN_ROL:
            begin
                sh_c = mcalu_pkg::msb_of(dm, byte_sel);
                sh_r = (shl | cin16) & m;
            end
            mcalu_pkg::FN_ASR:
            begin
                sh_c = dm[0];
                sh_r = (dm >> 1) | (dm & sb);
            end
            default:
            begin
                sh_c = mcalu_pkg::msb_of(dm, byte_sel);
                sh_r = shl & m;
            end
        endcase
    end
    assign sh_nz = mcalu_pkg::nz_of(sh_r, byte_sel);

    mcalu_branch u_branch (
        .branch_code (item.branch_code),
        .flags       (flags),
        .status      (br)
    );

    // Result, write-back and flag selection per operation.
    always_comb
    begin
        res.result       = 16'h0000;
        res.write_back   = 1'b0;
        res.new_flags    = flags;
        res.branch_taken = 1'b0;
        res.illegal      = 1'b0;
        case (mcalu_pkg::alu_func_t'(item.func))
            mcalu_pkg::FN_CLR:
            begin
                res.new_flags = 4'b0000;
                res.new_flags[mcalu_pkg::FLG_Z] = 1'b1;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_TST:
            begin
                res.result    = dm;
                res.new_flags = mcalu_pkg::nz_of(dm, byte_sel);
            end
            mcalu_pkg::FN_COM:
            begin
                res.result    = ~dm & m;
                res.new_flags = mcalu_pkg::nz_of(~dm & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = 1'b1;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_INC:
            begin
                res.result    = (dm + 16'd1) & m;
                res.new_flags = mcalu_pkg::nz_of((dm + 16'd1) & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] = (dm == (sb - 16'd1));
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_DEC:
            begin
                res.result    = (dm - 16'd1) & m;
                res.new_flags = mcalu_pkg::nz_of((dm - 16'd1) & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] = (dm == sb);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_NEG:
            begin
                res.result    = (16'h0000 - dm) & m;
                res.new_flags = mcalu_pkg::nz_of((16'h0000 - dm) & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] = (((16'h0000 - dm) & m) == sb);
                res.new_flags[mcalu_pkg::FLG_C] = (dm != 16'h0000);
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_ADC:
            begin
                res.result    = (dm + cin16) & m;
                res.new_flags = mcalu_pkg::nz_of((dm + cin16) & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] = cin && (dm == (sb - 16'd1));
                res.new_flags[mcalu_pkg::FLG_C] = cin && (dm == m);
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_SBC:
            begin
                res.result    = (dm - cin16) & m;
                res.new_flags = mcalu_pkg::nz_of((dm - cin16) & m, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] = cin && (dm == sb);
                res.new_flags[mcalu_pkg::FLG_C] = cin && (dm == 16'h0000);
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_ROR, mcalu_pkg::FN_ROL, mcalu_pkg::FN_ASR, mcalu_pkg::FN_ASL:
            begin
                res.result    = sh_r;
                res.new_flags = sh_nz;
                res.new_flags[mcalu_pkg::FLG_V] = sh_nz[mcalu_pkg::FLG_N] ^ sh_c;
                res.new_flags[mcalu_pkg::FLG_C] = sh_c;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_MOV:
            begin
                res.result    = sm;
                res.new_flags = mcalu_pkg::nz_of(sm, byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_CMP, mcalu_pkg::FN_SUB:
            begin
                res.result    = diff;
                res.new_flags = mcalu_pkg::nz_of(diff, byte_sel);
                res.new_flags[mcalu_pkg::FLG_V] =
                    mcalu_pkg::msb_of((diff_a ^ diff_b) & (diff_a ^ diff), byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = (diff_b > diff_a);
                res.write_back = (item.func == mcalu_pkg::FN_SUB);
            end
            mcalu_pkg::FN_BIT:
            begin
                res.result    = sm & dm;
                res.new_flags = mcalu_pkg::nz_of(sm & dm, byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
            end
            mcalu_pkg::FN_BIC:
            begin
                res.result    = ~sm & dm;
                res.new_flags = mcalu_pkg::nz_of(~sm & dm, byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_BIS:
            begin
                res.result    = sm | dm;
                res.new_flags = mcalu_pkg::nz_of(sm | dm, byte_sel);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_ADD:
            begin
                res.result    = add_r;
                res.new_flags = mcalu_pkg::nz_of(add_r, 1'b0);
                res.new_flags[mcalu_pkg::FLG_V] = (~(dm ^ sm) & (dm ^ add_r)) >= 16'h8000;
                res.new_flags[mcalu_pkg::FLG_C] = add_full[16];
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_SWAB:
            begin
                res.result    = {dm[7:0], dm[15:8]};
                res.new_flags = mcalu_pkg::nz_of({8'h00, dm[15:8]}, 1'b1);
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_SXT:
            begin
                res.result    = flags[mcalu_pkg::FLG_N] ? 16'hFFFF : 16'h0000;
                res.new_flags = 4'b0000;
                res.new_flags[mcalu_pkg::FLG_N] = flags[mcalu_pkg::FLG_N];
                res.new_flags[mcalu_pkg::FLG_Z] = !flags[mcalu_pkg::FLG_N];
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            mcalu_pkg::FN_CLF:
            begin
                res.new_flags = flags & ~item.flag_mask;
            end
            mcalu_pkg::FN_SEF:
            begin
                res.new_flags = flags | item.flag_mask;
            end
            mcalu_pkg::FN_BRT:
            begin
                res.branch_taken = br.taken;
                res.illegal      = br.bad;
            end
            mcalu_pkg::FN_XOR:
            begin
                res.result    = sm ^ dm;
                res.new_flags = mcalu_pkg::nz_of(sm ^ dm, 1'b0);
                res.new_flags[mcalu_pkg::FLG_C] = cin;
                res.write_back = 1'b1;
            end
            default:
            begin
                res.illegal = 1'b1;
            end
        endcase
    end

endmodule
